[hdl/dcf_pkg.sv]
package dcf_pkg;

  localparam int unsigned FrameBits   = 59;
  localparam int unsigned CountBits   = 6;
  localparam int unsigned DiffBits    = 16;
  localparam int unsigned ApbAddrBits = 4;
  localparam int unsigned ApbDataBits = 32;

  localparam logic [15:0] ThresholdReset = 16'd150;
  localparam logic [15:0] GapReset       = 16'd1600;

  localparam logic [1:0] RegEnabled   = 2'd0;
  localparam logic [1:0] RegThreshold = 2'd1;
  localparam logic [1:0] RegGap       = 2'd2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_RESTART,
    CMD_PULSE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    bit_val;
    logic    start_ok;
  } cmd_t;

endpackage

[hdl/dcf_if.sv]
interface dcf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] tick;
  logic        pin_level;

  modport source (output valid, output action, output tick, output pin_level, input ready);
  modport sink (input valid, input action, input tick, input pin_level, output ready);
endinterface

interface dcf_out_if;
  logic       valid;
  logic       ready;
  logic       time_valid;
  logic [6:0] minutes;
  logic [5:0] hours;
  logic [5:0] day_of_month;
  logic [2:0] day_of_week;
  logic [4:0] month;
  logic [7:0] year;
  logic [5:0] bits_collected;

  modport source (output valid, output time_valid, output minutes, output hours,
                  output day_of_month, output day_of_week, output month, output year,
                  output bits_collected, input ready);
  modport sink (input valid, input time_valid, input minutes, input hours,
                input day_of_month, input day_of_week, input month, input year,
                input bits_collected, output ready);
endinterface

[hdl/dcf_front.sv]
module dcf_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  dcf_in_if.sink       in_if,
  input  logic         enabled_i,
  input  logic [15:0]  one_bit_threshold_i,
  input  logic [15:0]  minute_gap_i,
  input  logic         full_i,
  output logic         push_o,
  output dcf_pkg::cmd_t cmd_o
);
  import dcf_pkg::*;

  logic                have_prev_q, have_prev_d;
  logic [DiffBits-1:0] prev_start_q, prev_start_d;
  logic [DiffBits-1:0] period_q, period_d;
  logic [DiffBits-1:0] diff;
  logic                accept;

  assign in_if.ready = !full_i;
  assign accept      = in_if.valid && !full_i;
  assign push_o      = accept;
  assign diff        = in_if.tick[DiffBits-1:0] - prev_start_q;

  always_comb begin
    have_prev_d    = have_prev_q;
    prev_start_d   = prev_start_q;
    period_d       = period_q;
    cmd_o.op       = CMD_NOP;
    cmd_o.bit_val  = (diff >= one_bit_threshold_i);
    cmd_o.start_ok = (period_q > minute_gap_i);
    if (in_if.action) begin
      cmd_o.op = CMD_RESTART;
    end else if (enabled_i) begin
      if (!have_prev_q) begin
        have_prev_d  = 1'b1;
        prev_start_d = in_if.tick[DiffBits-1:0];
      end else if (in_if.pin_level) begin
        period_d     = diff;
        prev_start_d = in_if.tick[DiffBits-1:0];
      end else begin
        cmd_o.op = CMD_PULSE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_start_q <= '0;
      period_q     <= '0;
    end else if (accept) begin
      have_prev_q  <= have_prev_d;
      prev_start_q <= prev_start_d;
      period_q     <= period_d;
    end
  end

endmodule

[hdl/dcf_queue.sv]
module dcf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dcf_pkg::cmd_t data_i,
  input  logic          pop_i,
  output dcf_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import dcf_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hdl/dcf_back.sv]
module dcf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dcf_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  dcf_out_if.source     out_if
);
  import dcf_pkg::*;

  function automatic logic [7:0] wt(input logic b, input logic [7:0] w);
    return b ? w : 8'd0;
  endfunction

  logic                 out_valid_q;
  logic [CountBits-1:0] bit_count_q, bit_count_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic                 received_q, received_d;
  logic [6:0]           minutes_q, minutes_d;
  logic [5:0]           hours_q, hours_d;
  logic [5:0]           mday_q, mday_d;
  logic [2:0]           wday_q, wday_d;
  logic [4:0]           month_q, month_d;
  logic [7:0]           year_q, year_d;
  logic [7:0]           min_sum, hour_sum, mday_sum, wday_sum, month_sum, year_sum;

  assign pop_o = !empty_i && (!out_valid_q || out_if.ready);

  always_comb begin
    min_sum   = wt(frame_q[21], 8'd1) + wt(frame_q[22], 8'd2) + wt(frame_q[23], 8'd4)
              + wt(frame_q[24], 8'd8) + wt(frame_q[25], 8'd10) + wt(frame_q[26], 8'd20)
              + wt(frame_q[27], 8'd40);
    hour_sum  = wt(frame_q[29], 8'd1) + wt(frame_q[30], 8'd2) + wt(frame_q[31], 8'd4)
              + wt(frame_q[32], 8'd8) + wt(frame_q[33], 8'd10) + wt(frame_q[34], 8'd20);
    mday_sum  = wt(frame_q[36], 8'd1) + wt(frame_q[37], 8'd2) + wt(frame_q[38], 8'd4)
              + wt(frame_q[39], 8'd8) + wt(frame_q[40], 8'd10) + wt(frame_q[41], 8'd20);
    wday_sum  = wt(frame_q[42], 8'd1) + wt(frame_q[43], 8'd2) + wt(frame_q[44], 8'd4);
    month_sum = wt(frame_q[45], 8'd1) + wt(frame_q[46], 8'd2) + wt(frame_q[47], 8'd4)
              + wt(frame_q[48], 8'd8) + wt(frame_q[49], 8'd10);
    year_sum  = wt(frame_q[50], 8'd1) + wt(frame_q[51], 8'd2) + wt(frame_q[52], 8'd4)
              + wt(frame_q[53], 8'd8) + wt(frame_q[54], 8'd10) + wt(frame_q[55], 8'd20)
              + wt(frame_q[56], 8'd40) + wt(frame_q[57], 8'd80);
  end

  always_comb begin
    bit_count_d = bit_count_q;
    frame_d     = frame_q;
    received_d  = received_q;
    minutes_d   = minutes_q;
    hours_d     = hours_q;
    mday_d      = mday_q;
    wday_d      = wday_q;
    month_d     = month_q;
    year_d      = year_q;
    case (cmd_i.op)
      CMD_RESTART: begin
        bit_count_d = '0;
        received_d  = 1'b0;
      end
      CMD_PULSE: begin
        if (bit_count_q != '0 || cmd_i.start_ok) begin
          if (bit_count_q < CountBits'(FrameBits)) begin
            frame_d[bit_count_q] = cmd_i.bit_val;
            bit_count_d          = bit_count_q + CountBits'(1);
          end else begin
            minutes_d   = min_sum[6:0];
            hours_d     = hour_sum[5:0];
            mday_d      = mday_sum[5:0];
            wday_d      = wday_sum[2:0];
            month_d     = month_sum[4:0];
            year_d      = year_sum;
            bit_count_d = '0;
            received_d  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bit_count_q <= '0;
      frame_q     <= '0;
      received_q  <= 1'b0;
      minutes_q   <= '0;
      hours_q     <= '0;
      mday_q      <= '0;
      wday_q      <= '0;
      month_q     <= '0;
      year_q      <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        bit_count_q <= bit_count_d;
        frame_q     <= frame_d;
        received_q  <= received_d;
        minutes_q   <= minutes_d;
        hours_q     <= hours_d;
        mday_q      <= mday_d;
        wday_q      <= wday_d;
        month_q     <= month_d;
        year_q      <= year_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.time_valid     = received_q;
  assign out_if.minutes        = minutes_q;
  assign out_if.hours          = hours_q;
  assign out_if.day_of_month   = mday_q;
  assign out_if.day_of_week    = wday_q;
  assign out_if.month          = month_q;
  assign out_if.year           = year_q;
  assign out_if.bits_collected = bit_count_q;

endmodule

[hdl/dcf77_time_frame_decoder_core.sv]
// DCF77 time-frame decoder. Each input word is a timestamped pin edge or a
// restart command; each one yields exactly one output word showing the frame
// state after it. Words are accepted one per cycle while the queue is not full;
// the front classifies the word in the accepting cycle and pushes a command
// into a two-entry queue, and the back end pops it into its state and output
// register once that register is free. While the output stalls, the queue
// takes up to two words before the input stalls. Registers on the APB port:
// 0x0 enable, 0x4 one-bit width threshold, 0x8 minute gap; write them only
// while no word is in flight.
module dcf77_time_frame_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dcf_in_if.sink                             in_if,
  dcf_out_if.source                          out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dcf_pkg::ApbAddrBits-1:0]    paddr,
  input  logic [dcf_pkg::ApbDataBits-1:0]    pwdata,
  output logic [dcf_pkg::ApbDataBits-1:0]    prdata,
  output logic                               pready
);
  import dcf_pkg::*;

  logic        enabled_q;
  logic [15:0] threshold_q;
  logic [15:0] gap_q;
  logic        cfg_we;
  logic        push, pop, full, empty;
  cmd_t        push_cmd, pop_cmd;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      threshold_q <= ThresholdReset;
      gap_q       <= GapReset;
    end else if (cfg_we) begin
      case (paddr[3:2])
        RegEnabled:   enabled_q   <= pwdata[0];
        RegThreshold: threshold_q <= pwdata[15:0];
        RegGap:       gap_q       <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegEnabled:   prdata = {{(ApbDataBits-1){1'b0}}, enabled_q};
      RegThreshold: prdata = {{(ApbDataBits-16){1'b0}}, threshold_q};
      RegGap:       prdata = {{(ApbDataBits-16){1'b0}}, gap_q};
      default:      prdata = '0;
    endcase
  end

  dcf_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_if               (in_if),
    .enabled_i           (enabled_q),
    .one_bit_threshold_i (threshold_q),
    .minute_gap_i        (gap_q),
    .full_i              (full),
    .push_o              (push),
    .cmd_o               (push_cmd)
  );

  dcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  dcf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pop_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

[tb/dcf77_time_frame_decoder_core_test.sv]
module dcf77_time_frame_decoder_core_test;
  import dcf_pkg::*;

  typedef struct packed {
    logic        action;
    logic [31:0] tick;
    logic        pin_level;
  } pin_word_t;

  typedef struct packed {
    logic       time_valid;
    logic [6:0] minutes;
    logic [5:0] hours;
    logic [5:0] day_of_month;
    logic [2:0] day_of_week;
    logic [4:0] month;
    logic [7:0] year;
    logic [5:0] bits_collected;
  } status_t;

  localparam int CycleLimit = 600000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ApbAddrBits-1:0] paddr;
  logic [ApbDataBits-1:0] pwdata;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  dcf_in_if  in_if ();
  dcf_out_if out_if ();

  dcf77_time_frame_decoder_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // configuration and state of the frame decoder as predicted
  logic        cfg_enabled;
  logic [15:0] cfg_threshold;
  logic [15:0] cfg_gap;
  logic        have_previous;
  logic [31:0] previous_start;
  logic [15:0] pulse_period;
  logic [5:0]  bit_count;
  logic [58:0] frame_bits;
  logic        received;
  status_t     decoded;

  pin_word_t pin_word_q[$];
  status_t   status_exp_q[$];
  pin_word_t offered_word;
  int        loaded_cnt;
  int        accepted_cnt;
  int        mismatch_cnt;
  int        cycle_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        recv_hold_cycles;
  logic [31:0] rise_tick;

  function automatic int bcd_weight(int i);
    case (i)
      0: return 1;
      1: return 2;
      2: return 4;
      3: return 8;
      4: return 10;
      5: return 20;
      6: return 40;
      default: return 80;
    endcase
  endfunction

  function automatic logic [7:0] bcd_sum(int first, int n);
    int sum = 0;
    for (int i = 0; i < n; i++) begin
      if (frame_bits[first + i]) sum += bcd_weight(i);
    end
    return sum[7:0];
  endfunction

  task automatic advance_decoder(input pin_word_t w);
    status_t     s;
    logic [31:0] span;
    if (w.action) begin
      bit_count = '0;
      received  = 1'b0;
    end else if (cfg_enabled) begin
      if (!have_previous) begin
        have_previous  = 1'b1;
        previous_start = w.tick;
      end else begin
        span = w.tick - previous_start;
        if (w.pin_level) begin
          pulse_period   = span[15:0];
          previous_start = w.tick;
        end else if (bit_count != 0 || pulse_period > cfg_gap) begin
          if (bit_count < FrameBits) begin
            frame_bits[bit_count] = (span[15:0] >= cfg_threshold);
            bit_count++;
          end else begin
            decoded.minutes      = 7'(bcd_sum(21, 7));
            decoded.hours        = 6'(bcd_sum(29, 6));
            decoded.day_of_month = 6'(bcd_sum(36, 6));
            decoded.day_of_week  = 3'(bcd_sum(42, 3));
            decoded.month        = 5'(bcd_sum(45, 5));
            decoded.year         = bcd_sum(50, 8);
            bit_count = '0;
            received  = 1'b1;
          end
        end
      end
    end
    s = decoded;
    s.time_valid     = received;
    s.bits_collected = bit_count;
    status_exp_q.push_back(s);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        advance_decoder(offered_word);
        accepted_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pin_word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_word = pin_word_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.action    <= offered_word.action;
          in_if.tick      <= offered_word.tick;
          in_if.pin_level <= offered_word.pin_level;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.time_valid, out_if.minutes, out_if.hours, out_if.day_of_month,
                out_if.day_of_week, out_if.month, out_if.year, out_if.bits_collected};
        if (status_exp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected status word %p", got);
        end else begin
          want = status_exp_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("status mismatch: valid %0d/%0d min %0d/%0d hr %0d/%0d dom %0d/%0d",
                       want.time_valid, got.time_valid, want.minutes, got.minutes,
                       want.hours, got.hours, want.day_of_month, got.day_of_month);
              $display("  dow %0d/%0d mon %0d/%0d yr %0d/%0d bits %0d/%0d (exp/act)",
                       want.day_of_week, got.day_of_week, want.month, got.month,
                       want.year, got.year, want.bits_collected, got.bits_collected);
            end
          end
        end
      end
      if (recv_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // count down the long receiver hold
  always @(posedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles--;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_word(logic action, logic [31:0] tick, logic pin_level);
    pin_word_t w;
    w = '{action, tick, pin_level};
    pin_word_q.push_back(w);
    loaded_cnt++;
  endtask

  task automatic drain();
    wait (accepted_cnt == loaded_cnt && status_exp_q.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrBits'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegEnabled:   cfg_enabled   = value[0];
      RegThreshold: cfg_threshold = value[15:0];
      RegGap:       cfg_gap       = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic logic [31:0] pulse_width(logic one);
    int w;
    if (one) w = int'(cfg_threshold) + $urandom_range(0, 300);
    else if (cfg_threshold == 0) w = 0;
    else w = int'(cfg_threshold) - 1 -
             $urandom_range(0, (cfg_threshold > 300) ? 300 : int'(cfg_threshold) - 1);
    if (w > 65535) w = 65535;
    if ($urandom_range(49) == 0) w += 65536;
    return w;
  endfunction

  // fill: 0 random bits, 1 all ones, 2 all zeros
  task automatic load_frame(int pulses, int fill);
    int   gap_period;
    logic one;
    gap_period = int'(cfg_gap) + 1 + $urandom_range(0, 400);
    if (gap_period > 65535) gap_period = 65535;
    if ($urandom_range(1)) push_word(1'b1, $urandom, 1'($urandom_range(1)));
    for (int i = 0; i < pulses; i++) begin
      one = (fill == 1) ? 1'b1 : (fill == 2) ? 1'b0 : 1'($urandom_range(1));
      rise_tick += (i == 0) ? gap_period : $urandom_range(900, 1100);
      push_word(1'b0, rise_tick, 1'b1);
      push_word(1'b0, rise_tick + pulse_width(one), 1'b0);
      if ($urandom_range(99) < 2) push_word(1'b1, $urandom, 1'($urandom_range(1)));
    end
  endtask

  task automatic load_noise(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        push_word(1'b1, $urandom, 1'($urandom_range(1)));
      end else begin
        rise_tick += $urandom_range(0, 70000);
        push_word(1'b0, ($urandom_range(3) == 0) ? $urandom : rise_tick,
                  1'($urandom_range(1)));
      end
    end
  endtask

  task automatic load_traffic(int n);
    int start;
    int r;
    start = loaded_cnt;
    while (loaded_cnt - start < n) begin
      r = $urandom_range(99);
      if (r < 60) load_frame(60, 0);
      else if (r < 70) load_frame($urandom_range(61, 64), 0);
      else if (r < 80) load_frame($urandom_range(1, 59), 0);
      else load_noise($urandom_range(3, 15));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.action    = 1'b0;
    in_if.tick      = '0;
    in_if.pin_level = 1'b0;
    out_if.ready    = 1'b0;
    cfg_enabled     = 1'b0;
    cfg_threshold   = ThresholdReset;
    cfg_gap         = GapReset;
    have_previous   = 1'b0;
    previous_start  = '0;
    pulse_period    = '0;
    bit_count       = '0;
    frame_bits      = '0;
    received        = 1'b0;
    decoded         = '0;
    loaded_cnt      = 0;
    accepted_cnt    = 0;
    mismatch_cnt    = 0;
    cycle_cnt       = 0;
    recv_hold_cycles = 0;
    rise_tick       = $urandom;
    set_idling(0, 0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // disabled: edges ignored, restart still applies
    push_word(1'b0, 32'h0000_0000, 1'b1);
    push_word(1'b0, 32'hFFFF_FFFF, 1'b0);
    push_word(1'b1, 32'hFFFF_FFFF, 1'b1);
    drain();
    write_reg(RegEnabled, {31'($urandom), 1'b1});

    push_word(1'b0, 32'h0000_0000, 1'b0);
    push_word(1'b0, 32'hFFFF_F000, 1'b1);
    push_word(1'b0, 32'hFFFF_F0C8, 1'b0);
    push_word(1'b0, 32'h0000_0000, 1'b0);
    push_word(1'b0, 32'hFFFF_F095, 1'b0);
    push_word(1'b0, 32'hFFFF_F096, 1'b0);
    push_word(1'b0, 32'h0001_2344, 1'b1);
    push_word(1'b0, 32'h0001_2344, 1'b0);
    push_word(1'b1, 32'h0000_0000, 1'b0);
    push_word(1'b0, 32'h0001_23A8, 1'b1);
    push_word(1'b0, 32'h0001_2400, 1'b0);
    push_word(1'b0, 32'hFFFF_FFFF, 1'b1);
    push_word(1'b0, 32'h0000_0000, 1'b1);
    push_word(1'b0, 32'h0000_0000, 1'b0);
    push_word(1'b1, 32'h0000_0000, 1'b1);
    drain();

    // hold the output long enough to back up the input
    recv_hold_cycles = 300;
    load_frame(60, 1);
    drain();

    write_reg(RegThreshold, {16'($urandom), 16'd0});
    write_reg(RegGap, {16'($urandom), 16'd0});
    set_idling(61, 0);
    load_traffic(40);
    drain();

    write_reg(RegThreshold, {16'($urandom), 16'hFFFF});
    write_reg(RegGap, 32'd1000);
    set_idling(0, 61);
    rise_tick = 32'hFFFF_0000;
    load_traffic(40);
    drain();

    write_reg(RegThreshold, 32'd1);
    write_reg(RegGap, {16'($urandom), 16'hFFFF});
    set_idling(12, 12);
    load_traffic(40);
    drain();

    write_reg(RegEnabled, {31'($urandom), 1'b0});
    set_idling(0, 0);
    load_noise(30);
    drain();

    write_reg(RegEnabled, 32'd1);
    write_reg(RegThreshold, 32'd400);
    write_reg(RegGap, 32'd2500);
    set_idling(12, 12);
    load_traffic(40);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && status_exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
